// ===== hw/rtl/thsd_pkg.sv =====
// Shared constants and types for the tagged header stream decoder.
`default_nettype none

package thsd_pkg;

	// Field widths
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned CODE_W   = 3;
	localparam int unsigned VALUE_W  = 64;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned GROUP_W  = 7;

	// Header byte decoding
	localparam logic [4:0] SHORT_MAX = 5'd22;
	localparam logic [4:0] LONG_MARK = 5'd31;

	// Length groups
	localparam logic [VALUE_W-1:0] MAX_VALUE_BYTES = 64'd8;
	localparam logic [6:0] SHIFT_LIMIT = 7'd64;
	localparam logic [6:0] GROUP_STEP  = 7'd7;
	// last shift position whose next step still lands at or below the limit
	localparam logic [6:0] SHIFT_SAT   = SHIFT_LIMIT - GROUP_STEP;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

	// One decoded header
	typedef struct packed {
		logic [CODE_W-1:0]   code;
		logic [VALUE_W-1:0]  value;
		logic [STATUS_W-1:0] status;
	} thsd_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tagged_header_stream_decoder.sv =====
// Top level of the tagged header stream decoder.
`default_nettype none

// Decodes type/length/value object headers from a byte stream. Each input
// transfer carries one byte; each output transfer carries one complete
// header: the 3-bit type code and status on tuser, the 64-bit value on tdata
// (zero when status is not ok). Short values, 1 to 8 following value bytes,
// and 7-bit length groups ended by a byte with bit 7 set are handled; payload
// bytes are not skipped, so the byte after a header is read as a new header.
// Rate: one byte per cycle sustained while the output side accepts results,
// with the decode state updated once for each byte. An input byte passes
// through the input register, then the result register. The input side
// stalls only while a result is held and the output side is not ready.
module tagged_header_stream_decoder
	import thsd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [VALUE_W-1:0]     m_axis_tdata,   // [63:0] header_value
	output logic [CODE_W+STATUS_W-1:0] m_axis_tuser // [2:0] header_code, [4:3] status
);

	logic              take;
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	thsd_result_t      res_q;

	thsd_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.take          (take),
		.valid_s1      (valid_s1),
		.byte_s1       (byte_s1)
	);

	thsd_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.byte_s1     (byte_s1),
		.take        (take),
		.res_valid_q (m_axis_tvalid),
		.res_ready   (m_axis_tready),
		.res_q       (res_q)
	);

	// result fields onto the output transfer
	assign m_axis_tdata = res_q.value;
	assign m_axis_tuser = {res_q.status, res_q.code};

endmodule

`default_nettype wire

// ===== hw/rtl/thsd_in_stage.sv =====
// Input register stage: captures one stream byte per transfer.
`default_nettype none

module thsd_in_stage
	import thsd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [BYTE_W-1:0] s_axis_tdata,   // data_byte
	input  wire logic              take,
	output logic                   valid_s1,
	output logic [BYTE_W-1:0]      byte_s1
);

	// room when empty or when the held byte leaves this cycle
	assign s_axis_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/thsd_core.sv =====
// Header decode state machine with the result register.
`default_nettype none

module thsd_core
	import thsd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_s1,
	input  wire logic [BYTE_W-1:0] byte_s1,
	output logic                   take,
	output logic                   res_valid_q,
	input  wire logic              res_ready,
	output thsd_result_t           res_q
);

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_VALUE  = 2'd1,
		PH_LENGTH = 2'd2
	} phase_t;

	phase_t               phase_q, phase_d;
	logic [CODE_W-1:0]    held_code_q, held_code_d;
	logic [VALUE_W-1:0]   value_acc_q, value_acc_d;
	logic [3:0]           bytes_rem_q, bytes_rem_d;
	logic [5:0]           byte_shift_q, byte_shift_d;
	logic [VALUE_W-1:0]   len_acc_q, len_acc_d;
	logic [6:0]           group_shift_q, group_shift_d;
	logic                 len_ovf_q, len_ovf_d;

	logic                 emit;
	thsd_result_t         res_d;
	logic [GROUP_W-1:0]   grp;
	logic [VALUE_W+GROUP_W-1:0] grp_wide;
	logic [4:0]           short_val;
	logic [4:0]           long_bytes;

	// byte moves on when the result register can take whatever it yields
	assign take = valid_s1 && (!res_valid_q || res_ready);

	assign grp        = byte_s1[GROUP_W-1:0];
	assign grp_wide   = {{VALUE_W{1'b0}}, grp} << group_shift_q[5:0];
	assign short_val  = byte_s1[7:3];
	assign long_bytes = short_val - SHORT_MAX;

	// next state and result for the byte in the input register
	always_comb begin
		phase_d       = phase_q;
		held_code_d   = held_code_q;
		value_acc_d   = value_acc_q;
		bytes_rem_d   = bytes_rem_q;
		byte_shift_d  = byte_shift_q;
		len_acc_d     = len_acc_q;
		group_shift_d = group_shift_q;
		len_ovf_d     = len_ovf_q;
		emit          = 1'b0;
		res_d.value   = '0;
		res_d.status  = ST_OK;

		case (phase_q)
			PH_VALUE: begin
				value_acc_d  = value_acc_q |
					({{(VALUE_W-BYTE_W){1'b0}}, byte_s1} << byte_shift_q);
				byte_shift_d = byte_shift_q + 6'd8;
				bytes_rem_d  = bytes_rem_q - 4'd1;
				if (bytes_rem_d == 4'd0) begin
					emit        = 1'b1;
					res_d.value = value_acc_d;
					phase_d     = PH_HEADER;
				end
			end
			PH_LENGTH: begin
				// past bit 63 any set group bit is lost
				if (group_shift_q >= SHIFT_LIMIT) begin
					if (grp != '0) len_ovf_d = 1'b1;
				end else begin
					len_acc_d = len_acc_q | grp_wide[VALUE_W-1:0];
					if (grp_wide[VALUE_W+GROUP_W-1:VALUE_W] != '0) len_ovf_d = 1'b1;
					group_shift_d = (group_shift_q >= SHIFT_SAT) ? SHIFT_LIMIT
						: group_shift_q + GROUP_STEP;
				end
				// terminator byte closes the length field
				if (byte_s1[7]) begin
					if (len_ovf_d) begin
						emit         = 1'b1;
						res_d.status = ST_OVERFLOW;
						phase_d      = PH_HEADER;
					end else if (len_acc_d > MAX_VALUE_BYTES) begin
						emit         = 1'b1;
						res_d.status = ST_TOO_LONG;
						phase_d      = PH_HEADER;
					end else if (len_acc_d == '0) begin
						emit    = 1'b1;
						phase_d = PH_HEADER;
					end else begin
						bytes_rem_d  = len_acc_d[3:0];
						value_acc_d  = '0;
						byte_shift_d = '0;
						phase_d      = PH_VALUE;
					end
				end
			end
			default: begin
				held_code_d = byte_s1[CODE_W-1:0];
				if (short_val <= SHORT_MAX) begin
					emit        = 1'b1;
					res_d.value = {{(VALUE_W-5){1'b0}}, short_val};
				end else if (short_val < LONG_MARK) begin
					bytes_rem_d  = long_bytes[3:0];
					value_acc_d  = '0;
					byte_shift_d = '0;
					phase_d      = PH_VALUE;
				end else begin
					len_acc_d     = '0;
					group_shift_d = '0;
					len_ovf_d     = 1'b0;
					phase_d       = PH_LENGTH;
				end
			end
		endcase

		res_d.code = held_code_d;
	end

	// decode state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			held_code_q   <= '0;
			value_acc_q   <= '0;
			bytes_rem_q   <= '0;
			byte_shift_q  <= '0;
			len_acc_q     <= '0;
			group_shift_q <= '0;
			len_ovf_q     <= 1'b0;
			res_valid_q   <= 1'b0;
			res_q         <= '0;
		end else begin
			if (take) begin
				phase_q       <= phase_d;
				held_code_q   <= held_code_d;
				value_acc_q   <= value_acc_d;
				bytes_rem_q   <= bytes_rem_d;
				byte_shift_q  <= byte_shift_d;
				len_acc_q     <= len_acc_d;
				group_shift_q <= group_shift_d;
				len_ovf_q     <= len_ovf_d;
			end
			if (take && emit) begin
				res_valid_q <= 1'b1;
				res_q       <= res_d;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ===== dv/tagged_header_stream_decoder_test.sv =====
// Self-checking stream testbench for the tagged header stream decoder.
`timescale 1ns / 100ps

module tagged_header_stream_decoder_test;
	import thsd_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned RANDOM_BYTES = 1400;

	// Decoder phases tracked by the predictor
	typedef enum logic [1:0] {
		DEC_HEADER = 2'd0,
		DEC_VALUE  = 2'd1,
		DEC_LENGTH = 2'd2
	} dec_phase_t;

	logic                       clk           = 1'b0;
	logic                       arst_n        = 1'b0;
	logic                       s_axis_tvalid = 1'b0;
	logic                       s_axis_tready;
	logic [BYTE_W-1:0]          s_axis_tdata  = '0;   // [7:0] data_byte
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	logic [VALUE_W-1:0]         m_axis_tdata;         // [63:0] header_value
	logic [CODE_W+STATUS_W-1:0] m_axis_tuser;         // [2:0] header_code, [4:3] status

	tagged_header_stream_decoder DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state
	dec_phase_t         dec_phase   = DEC_HEADER;
	logic [CODE_W-1:0]  cur_code    = '0;
	logic [VALUE_W-1:0] value_acc   = '0;
	logic [3:0]         value_left  = '0;
	logic [5:0]         value_pos   = '0;
	logic [VALUE_W-1:0] length_acc  = '0;
	logic [6:0]         group_pos   = '0;
	logic               length_ovf  = 1'b0;

	thsd_result_t pending_headers[$];
	int unsigned  error_count = 0;
	int unsigned  bytes_sent  = 0;
	int unsigned  burst_left  = 0;
	int unsigned  cycle_count = 0;

	// Receiver hold-off requests and stall pattern
	int unsigned hold_req   = 0;
	int unsigned hold_done  = 0;
	int unsigned hold_left  = 0;
	int unsigned run_left   = 0;
	logic        run_ready  = 1'b1;

	function automatic void expect_header(input logic [CODE_W-1:0] code,
			input logic [VALUE_W-1:0] value, input logic [STATUS_W-1:0] status);
		thsd_result_t r;
		r.code   = code;
		r.value  = value;
		r.status = status;
		pending_headers.insert(pending_headers.size(), r);
		dec_phase = DEC_HEADER;
	endfunction

	// Advance the predicted decoder by one accepted byte
	function automatic void decode_byte(input logic [BYTE_W-1:0] b);
		logic [GROUP_W-1:0] grp;
		logic [4:0]         short_val;
		logic [7:0]         next_pos;
		grp       = b[GROUP_W-1:0];
		short_val = b[7:3];
		case (dec_phase)
			DEC_VALUE: begin
				value_acc  = value_acc | (VALUE_W'(b) << value_pos);
				value_pos  = value_pos + 6'd8;
				value_left = value_left - 4'd1;
				if (value_left == 4'd0)
					expect_header(cur_code, value_acc, ST_OK);
			end
			DEC_LENGTH: begin
				if (group_pos >= SHIFT_LIMIT) begin
					if (grp != '0)
						length_ovf = 1'b1;
				end else begin
					length_acc = length_acc | (VALUE_W'(grp) << group_pos);
					// bits pushed past the top of the length are lost
					if (group_pos > SHIFT_SAT &&
							(VALUE_W'(grp) >> (SHIFT_LIMIT - group_pos)) != '0)
						length_ovf = 1'b1;
					next_pos  = 8'(group_pos) + 8'(GROUP_STEP);
					group_pos = (next_pos > 8'(SHIFT_LIMIT)) ? SHIFT_LIMIT : next_pos[6:0];
				end
				if (b[7]) begin
					if (length_ovf)
						expect_header(cur_code, '0, ST_OVERFLOW);
					else if (length_acc > MAX_VALUE_BYTES)
						expect_header(cur_code, '0, ST_TOO_LONG);
					else if (length_acc == '0)
						expect_header(cur_code, '0, ST_OK);
					else begin
						value_left = length_acc[3:0];
						value_acc  = '0;
						value_pos  = '0;
						dec_phase  = DEC_VALUE;
					end
				end
			end
			default: begin
				cur_code = b[CODE_W-1:0];
				if (short_val <= SHORT_MAX)
					expect_header(cur_code, VALUE_W'(short_val), ST_OK);
				else if (short_val < LONG_MARK) begin
					value_left = 4'(short_val - SHORT_MAX);
					value_acc  = '0;
					value_pos  = '0;
					dec_phase  = DEC_VALUE;
				end else begin
					length_acc = '0;
					group_pos  = '0;
					length_ovf = 1'b0;
					dec_phase  = DEC_LENGTH;
				end
			end
		endcase
	endfunction

	// Offer one byte, with random gaps between bursts; returns after the transfer
	task automatic send_byte(input logic [BYTE_W-1:0] b);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
		bytes_sent++;
		decode_byte(b);
	endtask

	// Header with 1..8 following value bytes
	task automatic send_fixed(input logic [CODE_W-1:0] code, input int unsigned n,
			input logic [VALUE_W-1:0] value);
		send_byte({5'(int'(SHORT_MAX) + n), code});
		for (int unsigned i = 0; i < n; i++)
			send_byte(value[8*i +: 8]);
	endtask

	// Header with a length in 7-bit groups (padded to ngroups), then value bytes for a length of 1 to 8
	task automatic send_long(input logic [CODE_W-1:0] code, input logic [VALUE_W-1:0] len,
			input int unsigned ngroups);
		int unsigned        n;
		logic [GROUP_W-1:0] grp;
		n = 1;
		while (n < 10 && (len >> (7 * n)) != '0)
			n++;
		if (ngroups > n)
			n = ngroups;
		send_byte({LONG_MARK, code});
		for (int unsigned i = 0; i < n; i++) begin
			grp = (i < 10) ? GROUP_W'(len >> (7 * i)) : '0;
			send_byte({(i == n - 1), grp});
		end
		if (len != '0 && len <= MAX_VALUE_BYTES)
			for (int unsigned i = 0; i < len; i++)
				send_byte(8'($urandom));
	endtask

	// Length whose groups reach past bit 63
	task automatic send_overflow(input logic [CODE_W-1:0] code, input int unsigned n);
		logic [GROUP_W-1:0] grp;
		send_byte({LONG_MARK, code});
		for (int unsigned i = 0; i < n; i++) begin
			grp = GROUP_W'($urandom);
			if (i == 9)
				grp = grp | 7'h02;
			send_byte({(i == n - 1), grp});
		end
	endtask

	task automatic test_directed_headers();
		send_byte(8'h00);                              // short value 0, code 0
		send_byte({SHORT_MAX, 3'd7});                  // largest short value
		send_fixed(3'd5, 8, '1);                       // eight value bytes, all ones
		send_long(3'd2, 64'd0, 1);                     // zero length
		send_long(3'd6, 64'd9, 1);                     // length above eight
		send_overflow(3'd7, 10);                       // length past 64 bits
	endtask

	task automatic test_random_headers();
		int unsigned        kind;
		int unsigned        n;
		logic [VALUE_W-1:0] len;
		while (bytes_sent < RANDOM_BYTES) begin
			kind = $urandom_range(0, 99);
			if (kind < 25)
				send_byte({5'($urandom_range(0, int'(SHORT_MAX))), 3'($urandom)});
			else if (kind < 60) begin
				n = $urandom_range(1, 8);
				send_fixed(3'($urandom), n, {$urandom, $urandom});
			end else if (kind < 85) begin
				len = 64'($urandom_range(0, 8));
				n   = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : 1;
				send_long(3'($urandom), len, n);
			end else if (kind < 90) begin
				len = {$urandom, $urandom} >> $urandom_range(0, 60);
				if (len <= MAX_VALUE_BYTES)
					len = len + 64'd9;
				send_long(3'($urandom), len, 1);
			end else if (kind < 95)
				send_overflow(3'($urandom), $urandom_range(10, 13));
			else
				send_byte(8'($urandom));                // noise: any byte as a header
		end
	endtask

	// Receiver holds off for a long stretch while bytes keep coming
	task automatic test_output_hold();
		hold_req   <= hold_req + 1;
		burst_left = 1000;
		for (int i = 0; i < 120; i++)
			send_byte({5'($urandom_range(0, int'(SHORT_MAX))), 3'($urandom)});
	endtask

	// Receiver ready: long hold-off on request, otherwise runs of ready and stall
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
			hold_left     <= hold_left - 1;
		end else if (hold_req != hold_done) begin
			hold_done     <= hold_req;
			hold_left     <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (run_left == 0) begin
			case ($urandom_range(0, 3))
				0: begin
					run_ready     <= 1'b1;
					run_left      <= $urandom_range(50, 150);
					m_axis_tready <= 1'b1;
				end
				1: begin
					run_ready     <= 1'b0;
					run_left      <= $urandom_range(1, 6);
					m_axis_tready <= 1'b0;
				end
				default: begin
					run_ready     <= 1'b1;
					run_left      <= $urandom_range(1, 30);
					m_axis_tready <= 1'b1;
				end
			endcase
		end else begin
			run_left      <= run_left - 1;
			m_axis_tready <= run_ready;
		end
	end

	// Compare each output transfer with the oldest predicted header
	always @(posedge clk) begin
		thsd_result_t exp_hdr;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_headers.size() == 0) begin
				$error("unexpected header transfer: code %0d value %h status %0d",
					m_axis_tuser[CODE_W-1:0], m_axis_tdata, m_axis_tuser[CODE_W +: STATUS_W]);
				error_count++;
			end else begin
				exp_hdr = pending_headers.pop_front();
				if (m_axis_tuser[CODE_W-1:0] !== exp_hdr.code) begin
					$error("header_code: expected %0d, actual %0d",
						exp_hdr.code, m_axis_tuser[CODE_W-1:0]);
					error_count++;
				end
				if (m_axis_tdata !== exp_hdr.value) begin
					$error("header_value: expected %h, actual %h", exp_hdr.value, m_axis_tdata);
					error_count++;
				end
				if (m_axis_tuser[CODE_W +: STATUS_W] !== exp_hdr.status) begin
					$error("status: expected %0d, actual %0d",
						exp_hdr.status, m_axis_tuser[CODE_W +: STATUS_W]);
					error_count++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[tagged_header_stream_decoder] ERROR");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_headers();
		test_random_headers();
		test_output_hold();
		s_axis_tvalid <= 1'b0;

		// drain, then watch for stray transfers
		while (pending_headers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_headers.size() != 0) begin
			$error("%0d predicted headers never arrived", pending_headers.size());
			error_count++;
		end

		if (error_count == 0)
			$display("[tagged_header_stream_decoder] OK");
		else
			$display("[tagged_header_stream_decoder] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/thsd_pkg.sv
hw/rtl/thsd_in_stage.sv
hw/rtl/thsd_core.sv
hw/rtl/tagged_header_stream_decoder.sv
dv/tagged_header_stream_decoder_test.sv
